// ===== sv/dru_pkg.sv =====
// dru_pkg: shared types and constants for the readout word unpacker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package dru_pkg;

    localparam int BOARDS   = 16;
    localparam int CHANNELS = 16;
    localparam int MAX_HITS = 64;

    localparam int MAP_DEPTH = BOARDS * CHANNELS;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);
    localparam int HIT_W     = 7;
    localparam int MPE_W     = 5;
    localparam int CNT_W     = 28;

    localparam logic OP_MAP  = 1'b0;
    localparam logic OP_WORD = 1'b1;

    localparam logic KIND_HIT = 1'b0;
    localparam logic KIND_END = 1'b1;

    localparam logic [7:0]  TAG_BOARD = 8'hFF;
    localparam logic [7:0]  TAG_CHAN  = 8'hF0;
    localparam logic [11:0] TAG_PAD   = 12'hADD;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_BOARD,
        PH_CHAN
    } t_phase;

    typedef struct packed {
        logic        op;
        logic [31:0] data_word;
        logic [3:0]  map_board;
        logic [3:0]  map_channel;
        logic        map_valid;
        logic [7:0]  map_detector;
        logic [7:0]  map_crystal;
    } t_in_beat;

    typedef struct packed {
        logic             kind;
        logic [HIT_W-1:0] hit_index;
        logic [7:0]       detector_id;
        logic [7:0]       crystal_id;
        logic [31:0]      board_time_low;
        logic [15:0]      board_time_high;
        logic [31:0]      channel_time_low;
        logic [15:0]      channel_time_high;
        logic [23:0]      energy;
        logic [5:0]       cf_fraction;
        logic             pileup;
        logic             overflow;
    } t_out_beat;

    typedef struct packed {
        logic              wr_en;
        logic              wr_valid;
        logic [MAP_AW-1:0] waddr;
        logic [7:0]        wr_det;
        logic [7:0]        wr_cry;
        logic              rd_en;
        logic              rd_ok;
        logic [MAP_AW-1:0] raddr;
    } t_map_req;

    typedef struct packed {
        logic       valid;
        logic [7:0] det;
        logic [7:0] cry;
    } t_map_entry;

endpackage

// ===== sv/dru_map.sv =====
// dru_map: board/channel to detector/crystal map table
// valid bits in flops, payload in a single-port-write memory; uses dru_pkg
`timescale 1ns / 1ps

module dru_map
    import dru_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_map_req   i_req,
    output t_map_entry o_entry
);

    logic [MAP_DEPTH-1:0] r_vbit;
    logic [15:0]          r_mem [MAP_DEPTH];
    logic                 r_ent_vld;
    logic [15:0]          r_ent_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbit    <= '0;
            r_ent_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vbit[i_req.waddr] <= i_req.wr_valid;
            end
            if (i_req.rd_en) begin
                r_ent_vld <= i_req.rd_ok && r_vbit[i_req.raddr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.waddr] <= {i_req.wr_det, i_req.wr_cry};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_ent_data <= r_mem[i_req.raddr];
        end
    end

    assign o_entry.valid = r_ent_vld;
    assign o_entry.det   = r_ent_data[15:8];
    assign o_entry.cry   = r_ent_data[7:0];

`ifndef SYNTHESIS
    a_no_rw_same_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_req.wr_en && i_req.rd_en))
        else $error("map table written and read in one cycle");

    a_rd_vld_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.rd_en && !i_req.rd_ok) |=> !r_ent_vld)
        else $error("out-of-table lookup gave a valid entry");

    a_entry_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.rd_en |=> $stable(r_ent_vld))
        else $error("pending entry changed without a lookup");
`endif

endmodule

// ===== sv/dru_parse.sv =====
// dru_parse: input register and readout word parser with hit/event-end assembly
// drives map table lookups and writes; uses dru_pkg
`timescale 1ns / 1ps

module dru_parse
    import dru_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    input  logic [MPE_W-1:0] i_mod_per_evt,
    input  logic             i_adv,
    output t_map_req         o_map_req,
    input  t_map_entry       i_pend,
    output logic [1:0]       o_res_cnt,
    output t_out_beat        o_res0,
    output t_out_beat        o_res1
);

    logic             r_in_vld;
    t_in_beat         r_in;
    t_phase           r_phase,       n_phase;
    logic [2:0]       r_wpos,        n_wpos;
    logic [7:0]       r_board,       n_board;
    logic [CNT_W-1:0] r_ch_left,     n_ch_left;
    logic [CNT_W-1:0] r_ch_in_board, n_ch_in_board;
    logic [MPE_W-1:0] r_mod_left,    n_mod_left;
    logic             r_evt_open,    n_evt_open;
    logic [31:0]      r_bt_lo,       n_bt_lo;
    logic [15:0]      r_bt_hi,       n_bt_hi;
    logic [HIT_W-1:0] r_hit_cnt,     n_hit_cnt;
    logic [15:0]      r_pt_hi,       n_pt_hi;
    logic [31:0]      r_pt_lo,       n_pt_lo;
    logic [31:0]      r_pe_word,     n_pe_word;

    logic             fire;
    logic [31:0]      w;
    logic [7:0]       top;
    logic             hdr_take;
    logic [MPE_W-1:0] reload;
    logic [MPE_W-1:0] ml_eff;
    logic [MPE_W-1:0] ml_dec;
    logic             fm_last;
    logic [CNT_W-1:0] cl_dec;
    logic             cl_done;
    logic [CNT_W-1:0] size_q;
    logic [CNT_W-1:0] size_ch;
    logic             hit_ok;
    logic             emit_hit;
    logic             emit_end;
    logic [HIT_W-1:0] hc_after;
    t_out_beat        hit_beat;
    t_out_beat        end_beat;

    // input register
    assign o_in_ready = !r_in_vld || i_adv;
    assign fire       = r_in_vld && i_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in <= i_in_data;
        end
    end

    // shared decode
    assign w        = r_in.data_word;
    assign top      = w[31:24];
    assign hdr_take = (w[31:20] != TAG_PAD) && ((top == TAG_BOARD) || (top == TAG_CHAN));
    assign reload   = (i_mod_per_evt == '0) ? MPE_W'(1) : i_mod_per_evt;
    assign ml_eff   = r_evt_open ? r_mod_left : reload;
    assign ml_dec   = (ml_eff != '0) ? ml_eff - MPE_W'(1) : '0;
    assign fm_last  = (ml_dec == '0);
    assign cl_dec   = (r_ch_left != '0) ? r_ch_left - CNT_W'(1) : '0;
    assign cl_done  = (cl_dec == '0);
    assign size_q   = w[31:4];
    assign size_ch  = (size_q == '0) ? '0 : size_q - CNT_W'(1);
    assign hit_ok   = i_pend.valid && (32'(r_hit_cnt) < MAX_HITS);
    assign hc_after = r_hit_cnt + HIT_W'(emit_hit);

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_wpos        = r_wpos;
        n_board       = r_board;
        n_ch_left     = r_ch_left;
        n_ch_in_board = r_ch_in_board;
        n_mod_left    = r_mod_left;
        n_evt_open    = r_evt_open;
        n_bt_lo       = r_bt_lo;
        n_bt_hi       = r_bt_hi;
        n_hit_cnt     = r_hit_cnt;
        n_pt_hi       = r_pt_hi;
        n_pt_lo       = r_pt_lo;
        n_pe_word     = r_pe_word;
        if (fire && (r_in.op == OP_WORD)) begin
            case (r_phase)
                PH_HEADER: begin
                    if (hdr_take) begin
                        n_evt_open = 1'b1;
                        n_mod_left = ml_eff;
                        if (top == TAG_BOARD) begin
                            n_board = w[23:16];
                            n_phase = PH_BOARD;
                            n_wpos  = 3'd1;
                        end else if (r_ch_in_board == '0) begin
                            if (fm_last) begin
                                n_hit_cnt  = '0;
                                n_evt_open = 1'b0;
                                n_mod_left = reload;
                                n_phase    = PH_HEADER;
                                n_wpos     = 3'd0;
                            end else begin
                                n_mod_left = ml_dec;
                            end
                        end else begin
                            n_ch_left = r_ch_in_board;
                            n_phase   = PH_CHAN;
                            n_pt_hi   = w[15:0];
                            n_wpos    = 3'd1;
                        end
                    end
                end
                PH_BOARD: begin
                    case (r_wpos)
                        3'd1: begin
                            n_ch_in_board = size_ch;
                            if ((size_ch == '0) && (r_mod_left != '0)) begin
                                n_mod_left = r_mod_left - MPE_W'(1);
                            end
                            n_wpos = 3'd2;
                        end
                        3'd2: begin
                            n_bt_hi = w[15:0];
                            n_wpos  = 3'd3;
                        end
                        3'd3: begin
                            n_bt_lo = w;
                            n_wpos  = 3'd4;
                        end
                        3'd4: begin
                            n_wpos = 3'd5;
                        end
                        default: begin
                            n_phase = PH_HEADER;
                            n_wpos  = 3'd0;
                            if (r_mod_left == '0) begin
                                n_hit_cnt  = '0;
                                n_evt_open = 1'b0;
                                n_mod_left = reload;
                            end
                        end
                    endcase
                end
                PH_CHAN: begin
                    case (r_wpos)
                        3'd0: begin
                            n_pt_hi = w[15:0];
                            n_wpos  = 3'd1;
                        end
                        3'd1: begin
                            n_pt_lo = w;
                            n_wpos  = 3'd2;
                        end
                        3'd2: begin
                            n_pe_word = w;
                            n_wpos    = 3'd3;
                        end
                        default: begin
                            n_wpos    = 3'd0;
                            n_hit_cnt = hc_after;
                            n_ch_left = cl_dec;
                            if (cl_done) begin
                                n_phase = PH_HEADER;
                                if (fm_last) begin
                                    n_hit_cnt  = '0;
                                    n_evt_open = 1'b0;
                                    n_mod_left = reload;
                                end else begin
                                    n_mod_left = ml_dec;
                                end
                            end
                        end
                    endcase
                end
                default: begin
                    n_phase = PH_HEADER;
                    n_wpos  = 3'd0;
                end
            endcase
        end
    end

    // outputs: map access and result beats
    always_comb begin
        o_map_req          = '0;
        o_map_req.wr_valid = r_in.map_valid;
        o_map_req.wr_det   = r_in.map_detector;
        o_map_req.wr_cry   = r_in.map_crystal;
        o_map_req.waddr    = MAP_AW'(32'(r_in.map_board) * CHANNELS + 32'(r_in.map_channel));
        o_map_req.raddr    = MAP_AW'(32'(r_board) * CHANNELS + 32'(w[23:16]));
        o_map_req.rd_ok    = (32'(r_board) < BOARDS) && (32'(w[23:16]) < CHANNELS);
        emit_hit           = 1'b0;
        emit_end           = 1'b0;
        if (fire) begin
            if (r_in.op == OP_MAP) begin
                o_map_req.wr_en = (32'(r_in.map_board) < BOARDS)
                               && (32'(r_in.map_channel) < CHANNELS);
            end else begin
                case (r_phase)
                    PH_HEADER: begin
                        if (hdr_take && (top == TAG_CHAN)) begin
                            if (r_ch_in_board == '0) begin
                                emit_end = fm_last;
                            end else begin
                                o_map_req.rd_en = 1'b1;
                            end
                        end
                    end
                    PH_BOARD: begin
                        if (!(r_wpos inside {[3'd1:3'd4]})) begin
                            emit_end = (r_mod_left == '0);
                        end
                    end
                    PH_CHAN: begin
                        case (r_wpos)
                            3'd0: begin
                                o_map_req.rd_en = 1'b1;
                            end
                            3'd1, 3'd2: begin
                            end
                            default: begin
                                emit_hit = hit_ok;
                                emit_end = cl_done && fm_last;
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_comb begin
        hit_beat                   = '0;
        hit_beat.kind              = KIND_HIT;
        hit_beat.hit_index         = r_hit_cnt;
        hit_beat.detector_id       = i_pend.det;
        hit_beat.crystal_id        = i_pend.cry;
        hit_beat.board_time_low    = r_bt_lo;
        hit_beat.board_time_high   = r_bt_hi;
        hit_beat.channel_time_low  = r_pt_lo;
        hit_beat.channel_time_high = r_pt_hi;
        hit_beat.energy            = r_pe_word[23:0];
        hit_beat.cf_fraction       = r_pe_word[29:24];
        hit_beat.pileup            = r_pe_word[30];
        hit_beat.overflow          = r_pe_word[31];

        end_beat           = '0;
        end_beat.kind      = KIND_END;
        end_beat.hit_index = hc_after;

        o_res0    = emit_hit ? hit_beat : end_beat;
        o_res1    = end_beat;
        o_res_cnt = 2'(emit_hit) + 2'(emit_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_HEADER;
            r_wpos        <= '0;
            r_board       <= '0;
            r_ch_left     <= '0;
            r_ch_in_board <= '0;
            r_mod_left    <= MPE_W'(1);
            r_evt_open    <= 1'b0;
            r_bt_lo       <= '0;
            r_bt_hi       <= '0;
            r_hit_cnt     <= '0;
            r_pt_hi       <= '0;
            r_pt_lo       <= '0;
            r_pe_word     <= '0;
        end else begin
            r_phase       <= n_phase;
            r_wpos        <= n_wpos;
            r_board       <= n_board;
            r_ch_left     <= n_ch_left;
            r_ch_in_board <= n_ch_in_board;
            r_mod_left    <= n_mod_left;
            r_evt_open    <= n_evt_open;
            r_bt_lo       <= n_bt_lo;
            r_bt_hi       <= n_bt_hi;
            r_hit_cnt     <= n_hit_cnt;
            r_pt_hi       <= n_pt_hi;
            r_pt_lo       <= n_pt_lo;
            r_pe_word     <= n_pe_word;
        end
    end

`ifndef SYNTHESIS
    a_hit_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_hit_cnt) <= MAX_HITS)
        else $error("hit counter beyond cap");

    a_board_wpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BOARD) |-> ((r_wpos >= 3'd1) && (r_wpos <= 3'd5)))
        else $error("board word position out of range");

    a_chan_wpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CHAN) |-> ((r_wpos <= 3'd3) && r_evt_open && (r_ch_left != '0)))
        else $error("channel parse without open event or channels");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_cnt == 2'd2) |-> ((o_res0.kind == KIND_HIT) && (o_res1.kind == KIND_END)))
        else $error("two results must be hit then event end");
`endif

endmodule

// ===== sv/dru_outq.sv =====
// dru_outq: three-slot result queue, takes up to two beats, gives one per cycle
// while i_out_ready is high; head slot is the output register; uses dru_pkg
`timescale 1ns / 1ps

module dru_outq
    import dru_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic [1:0] i_res_cnt,
    input  t_out_beat i_res0,
    input  t_out_beat i_res1,
    output logic      o_adv,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_beat o_out_data
);

    t_out_beat  r_slot [3];
    t_out_beat  n_slot [3];
    logic [1:0] r_cnt, n_cnt;
    logic       pop;
    logic [1:0] base;

    assign o_adv       = (r_cnt <= 2'd1);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_out_data  = r_slot[0];
    assign pop         = o_out_valid && i_out_ready;
    assign base        = r_cnt - 2'(pop);

    always_comb begin
        n_slot = r_slot;
        if (pop) begin
            n_slot[0] = r_slot[1];
            n_slot[1] = r_slot[2];
        end
        for (int i = 0; i < 3; i++) begin
            if ((i_res_cnt != 2'd0) && (2'(i) == base)) begin
                n_slot[i] = i_res0;
            end
            if ((i_res_cnt == 2'd2) && (2'(i) == base + 2'd1)) begin
                n_slot[i] = i_res1;
            end
        end
        n_cnt = base + i_res_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_cnt != 2'd0) |-> (r_cnt <= 2'd1))
        else $error("results pushed into a full queue");

    a_res_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_cnt != 2'd3)
        else $error("more than two results from one beat");

    a_cnt_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!pop && (i_res_cnt == 2'd0)) |=> $stable(r_cnt))
        else $error("queue level moved without push or pop");
`endif

endmodule

// ===== sv/detector_readout_word_unpacker.sv =====
// detector_readout_word_unpacker: top level, config register and unit wiring
// depends on dru_pkg, dru_map, dru_parse, dru_outq
//
//   port group  dir  payload     notes
//   i_in_*      in   t_in_beat   map load or readout word
//   o_out_*     out  t_out_beat  channel hit or event end
//   i_cfg_*     in   5 bits      modules per event
//
// one input beat per cycle while o_in_ready is high; each beat is held in the input register and
// its results are written into the result queue when it advances
// a beat gives up to two results; the queue drains one per cycle while i_out_ready is high, so a
// beat that gives two takes an extra output beat under a continuous stream
// synchronous active-low reset: map table all invalid, parser awaits a header
// o_in_ready drops only while the result queue holds two or more beats
`timescale 1ns / 1ps

module detector_readout_word_unpacker
    import dru_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_beat         i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_beat        o_out_data,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [MPE_W-1:0] i_cfg_data
);

    logic [MPE_W-1:0] r_mod_per_evt;
    t_map_req         map_req;
    t_map_entry       pend;
    logic             adv;
    logic [1:0]       res_cnt;
    t_out_beat        res0;
    t_out_beat        res1;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_per_evt <= MPE_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mod_per_evt <= i_cfg_data;
        end
    end

    dru_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (map_req),
        .o_entry (pend)
    );

    dru_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .i_mod_per_evt (r_mod_per_evt),
        .i_adv         (adv),
        .o_map_req     (map_req),
        .i_pend        (pend),
        .o_res_cnt     (res_cnt),
        .o_res0        (res0),
        .o_res1        (res1)
    );

    dru_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_cnt   (res_cnt),
        .i_res0      (res0),
        .i_res1      (res1),
        .o_adv       (adv),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
